// ----- hw/rtl/assert_macros.svh -----
// assertion helper macros for the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define PTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("scheduler assertion failed");

// condition in one cycle implies consequence in the next
`define PTS_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("scheduler assertion failed");

`else

`define PTS_ASSERT(lbl, prop)
`define PTS_ASSERT_NEXT(lbl, cond, cons)

`endif

`endif

// ----- hw/rtl/pts_pkg.sv -----
// types and constants shared by the scheduler modules
package pts_pkg;

    localparam int MAX_TASKS = 4;

    // operation codes
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_RAISE    = 3'd1,
        OP_CANCEL   = 3'd2,
        OP_SET_PEND = 3'd3,
        OP_CLR_PEND = 3'd4,
        OP_POLL     = 3'd5
    } t_op;

    // configuration register indexes
    localparam logic [3:0] CFG_AUTO_BASE  = 4'd0;
    localparam logic [3:0] CFG_LIMIT_BASE = 4'd4;

    // input request payload
    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  task_index;
        logic [31:0] now;
    } t_in_req;

    // result payload
    typedef struct packed {
        logic [3:0] pending_mask;
        logic       any_pending;
        logic [3:0] fired_mask;
        logic       task_is_pending;
    } t_out_req;

    // per-request control broadcast to every cell
    typedef struct packed {
        logic        accept;
        logic [2:0]  op;
        logic [31:0] dt;
    } t_cell_ctl;

    // configuration write strobes for one cell
    typedef struct packed {
        logic        auto_we;
        logic        limit_we;
        logic [23:0] data;
    } t_cell_cfg;

    // data handed from cell to cell along the chain
    typedef struct packed {
        logic [3:0] pend_mask;
        logic [3:0] fired_mask;
        logic       sel_pend;
    } t_chain;

endpackage

// ----- hw/rtl/pts_task_cell.sv -----
// one task cell: counter, request flag, pending bit and its two periods
module pts_task_cell
    import pts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell_cfg i_cfg,
    input  logic      i_sel,
    input  t_chain    i_chain,
    output t_chain    o_chain
);

    logic [31:0] r_elapsed;
    logic        r_req;
    logic        r_pend;
    logic [23:0] r_auto;
    logic [23:0] r_limit;

    logic [31:0] n_elapsed;
    logic        n_req;
    logic        n_pend;
    logic        w_fired;

    logic [32:0] w_sum;
    logic [31:0] w_cnt;
    logic        w_may_fire;
    logic        w_auto_fire;

    // saturating counter update and firing decision
    assign w_sum       = {1'b0, r_elapsed} + {1'b0, i_ctl.dt};
    assign w_cnt       = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_may_fire  = (r_limit == 24'd0) || (w_cnt >= {8'd0, r_limit});
    assign w_auto_fire = (r_auto != 24'd0) && (w_cnt >= {8'd0, r_auto});

    // next state per operation
    always_comb begin
        n_elapsed = r_elapsed;
        n_req     = r_req;
        n_pend    = r_pend;
        w_fired   = 1'b0;
        unique case (i_ctl.op)
            OP_TICK: begin
                n_elapsed = w_cnt;
                if (w_may_fire && (w_auto_fire || r_req)) begin
                    w_fired   = 1'b1;
                    n_elapsed = 32'd0;
                    n_pend    = 1'b1;
                    if (!w_auto_fire) begin
                        n_req = 1'b0;
                    end
                end
            end
            OP_RAISE: begin
                if (i_sel) begin
                    n_req = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (i_sel) begin
                    n_req = 1'b0;
                end
            end
            OP_SET_PEND: begin
                if (i_sel) begin
                    n_pend = 1'b1;
                end
            end
            OP_CLR_PEND: begin
                if (i_sel) begin
                    n_pend = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // task state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= 32'd0;
            r_req     <= 1'b0;
            r_pend    <= 1'b0;
        end else if (i_ctl.accept) begin
            r_elapsed <= n_elapsed;
            r_req     <= n_req;
            r_pend    <= n_pend;
        end
    end

    // period registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto  <= 24'd0;
            r_limit <= 24'd0;
        end else begin
            if (i_cfg.auto_we) begin
                r_auto <= i_cfg.data;
            end
            if (i_cfg.limit_we) begin
                r_limit <= i_cfg.data;
            end
        end
    end

    // shift this task's bits into the chain
    assign o_chain.pend_mask  = {i_chain.pend_mask[2:0], n_pend};
    assign o_chain.fired_mask = {i_chain.fired_mask[2:0], w_fired};
    assign o_chain.sel_pend   = i_chain.sel_pend | (i_sel & r_pend);

endmodule

// ----- hw/rtl/periodic_task_request_scheduler.sv -----
// top level of the rate-limited periodic task scheduler
//
//  port group   dir  handshake                 payload
//  i_in_*       in   i_in_valid / o_in_stall   t_in_req  (operation, task_index, now)
//  o_out_*      out  o_out_valid / i_out_stall t_out_req (masks, pending flags)
//  i_cfg_*      in   i_cfg_valid / o_cfg_ready index 0..7, 24 bit period data
//
// one request per cycle while o_in_stall is low; each result is registered for output.
// the cell chain updates every task counter on a tick, in the cycle it is accepted.
// a skid register holds one result while the output is stalled, so input stalls
// only when both the output and skid registers are full.
// reset is synchronous and clears all counters, flags, periods and last timestamp.
`include "assert_macros.svh"

module periodic_task_request_scheduler
    import pts_pkg::*;
#(
    parameter int TASKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [31:0] r_last_time;
    logic        r_out_valid;
    t_out_req    r_out;
    logic        r_skid_valid;
    t_out_req    r_skid;

    logic        w_accept;
    logic        w_take;
    logic        w_cfg_we;
    t_cell_ctl   w_ctl;
    t_out_req    w_res;
    t_chain      w_chain [TASKS+1];

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // broadcast control for the cells
    assign w_ctl.accept = w_accept;
    assign w_ctl.op     = i_in_data.operation;
    assign w_ctl.dt     = i_in_data.now - r_last_time;

    assign w_chain[TASKS] = '0;

    // row of task cells, highest task first
    for (genvar gi = 0; gi < TASKS; gi++) begin : g_cell
        t_cell_cfg w_cfg;
        logic      w_sel;

        assign w_sel          = (i_in_data.task_index == 2'(gi));
        assign w_cfg.auto_we  = w_cfg_we && (i_cfg_index == CFG_AUTO_BASE + 4'(gi));
        assign w_cfg.limit_we = w_cfg_we && (i_cfg_index == CFG_LIMIT_BASE + 4'(gi));
        assign w_cfg.data     = i_cfg_data;

        pts_task_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_cfg   (w_cfg),
            .i_sel   (w_sel),
            .i_chain (w_chain[gi+1]),
            .o_chain (w_chain[gi])
        );
    end

    // assemble the result
    assign w_res.pending_mask    = w_chain[0].pend_mask;
    assign w_res.any_pending     = |w_chain[0].pend_mask;
    assign w_res.fired_mask      = w_chain[0].fired_mask;
    assign w_res.task_is_pending = w_chain[0].sel_pend;

    // timestamp of the last tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= 32'd0;
        end else if (w_accept && (i_in_data.operation == OP_TICK)) begin
            r_last_time <= i_in_data.now;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_res;
            end
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `PTS_ASSERT(a_skid_needs_out, !r_skid_valid || r_out_valid)
    `PTS_ASSERT(a_fired_pend, !o_out_valid || ~|(o_out_data.fired_mask & ~o_out_data.pending_mask))
    `PTS_ASSERT(a_any_matches_mask, !o_out_valid || (o_out_data.any_pending == (|o_out_data.pending_mask)))
    `PTS_ASSERT_NEXT(a_stall_fills_skid, w_accept && r_out_valid && i_out_stall, r_skid_valid)

endmodule
